// File: rtl/core/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the scaled glyph row rasterizer.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int DEF_MAX_GLYPH_WIDTH  = 64;
  localparam int DEF_MAX_GLYPH_HEIGHT = 64;
  localparam int DEF_STORE_BYTES      = 512;

  localparam int DIM_W   = 7;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 6;
  localparam int MASK_W  = 64;
  localparam int BADDR_W = 9;
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 8;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  localparam logic [DIM_W-1:0]   RST_GLYPH_WIDTH   = 7'd8;
  localparam logic [DIM_W-1:0]   RST_GLYPH_HEIGHT  = 7'd8;
  localparam logic [DIM_W-1:0]   RST_TARGET_WIDTH  = 7'd8;
  localparam logic [DIM_W-1:0]   RST_TARGET_HEIGHT = 7'd8;
  localparam logic [COLOR_W-1:0] RST_DRAW_COLOR    = 8'd0;

  localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [2:0] REG_DRAW_COLOR    = 3'd4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_FILL,
    ST_COL,
    ST_DONE
  } sgr_state_e;

  typedef struct packed {
    logic [0:0]         operation;
    logic [BADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]  byte_value;
    logic [ROW_W-1:0]   target_row;
  } sgr_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [MASK_W-1:0]  row_mask;
    logic [COLOR_W-1:0] pixel_color;
  } sgr_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]   glyph_width;
    logic [DIM_W-1:0]   glyph_height;
    logic [DIM_W-1:0]   target_width;
    logic [DIM_W-1:0]   target_height;
    logic [COLOR_W-1:0] draw_color;
  } sgr_cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [DIM_W-1:0] sub_d;
    logic [DIM_W-1:0] add_d;
  } sgr_alu_req_t;

  typedef struct packed {
    logic             ge;
    logic [ACC_W-1:0] res;
  } sgr_alu_rsp_t;

endpackage

// File: rtl/core/scaled_glyph_row_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// scaled_glyph_row_rasterizer_unit
// Nearest-neighbor scaled glyph row rasterizer with a sequenced DDA unit.
//
//   channel | direction | handshake         | beat payload
//   --------+-----------+-------------------+--------------------------------
//   in      | input     | in_valid/in_stall | sgr_in_t: load byte or render
//   out     | output    | out_valid/stall   | sgr_out_t: row, mask, color
//   cfg     | input     | APB, pready = 1   | dims and color at 4*index
//
// A render beat runs one shared subtract-or-add step per cycle, first for
// the source row, then for each output column, plus one read per source
// byte of the row.
// Reset clears control state only; the glyph store is undefined until loaded.
// in_stall is high while a render is in flight; a finished mask waits in the
// output register while new beats are taken.
// ----------------------------------------------------------------------------
module scaled_glyph_row_rasterizer_unit
  import sgr_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
  parameter int STORE_BYTES      = DEF_STORE_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sgr_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sgr_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PIX_W     = $clog2(MAX_GLYPH_WIDTH);
  localparam int ROW_BITS  = 2 ** PIX_W;
  localparam int ROW_BYTES = ROW_BITS / 8;
  localparam int KW        = PIX_W - 2;
  localparam int RD_AW     = $clog2(MAX_GLYPH_HEIGHT * ROW_BYTES);

  sgr_cfg_t     cfg;
  sgr_alu_req_t alu_req;
  sgr_alu_rsp_t alu_rsp;

  sgr_state_e          state_q, state_d;
  logic [ACC_W-1:0]    r_q, r_d;
  logic [ROW_W-1:0]    y_q, y_d;
  logic [ROW_W-1:0]    i_q, i_d;
  logic [RD_AW-1:0]    base_q, base_d;
  logic [KW-1:0]       k_q, k_d;
  logic [PIX_W-1:0]    sx_q, sx_d;
  logic [ROW_W-1:0]    x_q, x_d;
  logic [MASK_W-1:0]   mask_q, mask_d;
  logic                rd_vld_q, rd_vld_d;
  logic [KW-1:0]       rd_k_q, rd_k_d;
  logic                out_vld_q, out_vld_d;
  sgr_out_t            out_q, out_d;
  logic [ROW_BITS-1:0] rowbuf_q;

  logic              in_acc;
  logic              render_acc;
  logic              skip;
  logic              out_free;
  logic [KW-1:0]     rb;
  logic [ROW_W-1:0]  x_last;
  logic              pix;
  logic              rd_en;
  logic [RD_AW-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  sgr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sgr_step_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  sgr_glyph_mem #(
    .STORE_BYTES (STORE_BYTES),
    .RD_AW       (RD_AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && (in_data_i.operation == OP_LOAD)),
    .wr_addr_i (in_data_i.byte_address),
    .wr_data_i (in_data_i.byte_value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign render_acc  = in_acc && (in_data_i.operation == OP_RENDER);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_vld_q || !out_stall_i;

  assign skip = (cfg.glyph_width == '0) || (cfg.glyph_height == '0) ||
                (cfg.target_width == '0) || (cfg.target_height == '0) ||
                (32'(cfg.glyph_width) > 32'(MAX_GLYPH_WIDTH)) ||
                (32'(cfg.glyph_height) > 32'(MAX_GLYPH_HEIGHT)) ||
                (DIM_W'(in_data_i.target_row) >= cfg.target_height);

  assign rb      = KW'((ACC_W'(cfg.glyph_width) + ACC_W'(7)) >> 3);
  assign x_last  = cfg.target_width[6] ? ROW_W'(MASK_W - 1)
                                       : ROW_W'(cfg.target_width - DIM_W'(1));
  assign pix     = rowbuf_q[sx_q ^ PIX_W'(7)];
  assign rd_en   = (state_q == ST_FILL) && (k_q != rb);
  assign rd_addr = base_q + RD_AW'(k_q);

  assign alu_req.acc   = r_q;
  assign alu_req.sub_d = (state_q == ST_ROW) ? cfg.target_height : cfg.target_width;
  assign alu_req.add_d = (state_q == ST_ROW) ? cfg.glyph_height : cfg.glyph_width;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (render_acc) state_d = skip ? ST_DONE : ST_ROW;
      ST_ROW:  if (!alu_rsp.ge && (i_q == y_q)) state_d = ST_FILL;
      ST_FILL: if ((k_q == rb) && !rd_vld_q) state_d = ST_COL;
      ST_COL:  if (!alu_rsp.ge && (x_q == x_last)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    r_d       = r_q;
    y_d       = y_q;
    i_d       = i_q;
    base_d    = base_q;
    k_d       = k_q;
    sx_d      = sx_q;
    x_d       = x_q;
    mask_d    = mask_q;
    rd_vld_d  = 1'b0;
    rd_k_d    = rd_k_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (render_acc) begin
          y_d    = in_data_i.target_row;
          r_d    = '0;
          i_d    = '0;
          base_d = '0;
          k_d    = '0;
          mask_d = '0;
        end
      end
      ST_ROW: begin
        if (alu_rsp.ge) begin
          r_d    = alu_rsp.res;
          base_d = base_q + RD_AW'(rb);
        end else if (i_q != y_q) begin
          r_d = alu_rsp.res;
          i_d = i_q + ROW_W'(1);
        end
      end
      ST_FILL: begin
        if (rd_en) begin
          k_d      = k_q + KW'(1);
          rd_vld_d = 1'b1;
          rd_k_d   = k_q;
        end
        r_d  = '0;
        sx_d = '0;
        x_d  = '0;
      end
      ST_COL: begin
        r_d = alu_rsp.res;
        if (alu_rsp.ge) begin
          sx_d = sx_q + PIX_W'(1);
        end else begin
          mask_d[x_q] = pix;
          if (x_q != x_last) begin
            x_d = x_q + ROW_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          out_d.row_index   = y_q;
          out_d.row_mask    = mask_q;
          out_d.pixel_color = cfg.draw_color;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    y_q    <= y_d;
    i_q    <= i_d;
    base_q <= base_d;
    k_q    <= k_d;
    sx_q   <= sx_d;
    x_q    <= x_d;
    mask_q <= mask_d;
    rd_k_q <= rd_k_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int j = 0; j < ROW_BYTES; j++) begin
        if (rd_k_q == KW'(j)) begin
          rowbuf_q[8*j +: 8] <= rd_data;
        end
      end
    end
  end

  a_col_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COL |-> !rd_vld_q)
    else $error("column walk started with a source byte still in flight");

  a_rd_only_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == ST_FILL))
    else $error("store read issued outside the row fill");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result beat raised without a finished row");

  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    render_acc |=> state_q != ST_IDLE)
    else $error("render beat taken but sequencer stayed idle");

endmodule

// File: rtl/core/sgr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sgr_cfg_regs
// APB register file: glyph and target dimensions, draw color.
// ----------------------------------------------------------------------------
module sgr_cfg_regs
  import sgr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output sgr_cfg_t          cfg_o
);

  sgr_cfg_t   cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width   <= RST_GLYPH_WIDTH;
      cfg_q.glyph_height  <= RST_GLYPH_HEIGHT;
      cfg_q.target_width  <= RST_TARGET_WIDTH;
      cfg_q.target_height <= RST_TARGET_HEIGHT;
      cfg_q.draw_color    <= RST_DRAW_COLOR;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= pwdata[DIM_W-1:0];
        REG_GLYPH_HEIGHT:  cfg_q.glyph_height  <= pwdata[DIM_W-1:0];
        REG_TARGET_WIDTH:  cfg_q.target_width  <= pwdata[DIM_W-1:0];
        REG_TARGET_HEIGHT: cfg_q.target_height <= pwdata[DIM_W-1:0];
        REG_DRAW_COLOR:    cfg_q.draw_color    <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GLYPH_WIDTH:   prdata = APB_DW'(cfg_q.glyph_width);
      REG_GLYPH_HEIGHT:  prdata = APB_DW'(cfg_q.glyph_height);
      REG_TARGET_WIDTH:  prdata = APB_DW'(cfg_q.target_width);
      REG_TARGET_HEIGHT: prdata = APB_DW'(cfg_q.target_height);
      REG_DRAW_COLOR:    prdata = APB_DW'(cfg_q.draw_color);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/sgr_step_alu.sv
// ----------------------------------------------------------------------------
// sgr_step_alu
// Shared DDA step: subtract the divisor when it fits, else add the step.
// ----------------------------------------------------------------------------
module sgr_step_alu
  import sgr_pkg::*;
(
  input  sgr_alu_req_t req_i,
  output sgr_alu_rsp_t rsp_o
);

  logic ge;

  assign ge        = req_i.acc >= ACC_W'(req_i.sub_d);
  assign rsp_o.ge  = ge;
  assign rsp_o.res = ge ? req_i.acc - ACC_W'(req_i.sub_d)
                        : req_i.acc + ACC_W'(req_i.add_d);

endmodule

// File: rtl/core/sgr_glyph_mem.sv
// ----------------------------------------------------------------------------
// sgr_glyph_mem
// Glyph bitmap store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgr_glyph_mem
  import sgr_pkg::*;
#(
  parameter int STORE_BYTES = DEF_STORE_BYTES,
  parameter int RD_AW       = 9
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [BADDR_W-1:0] wr_addr_i,
  input  logic [BYTE_W-1:0]  wr_data_i,
  input  logic               rd_en_i,
  input  logic [RD_AW-1:0]   rd_addr_i,
  output logic [BYTE_W-1:0]  rd_data_o
);

  localparam int SAW = $clog2(STORE_BYTES);

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] rd_data_q;
  logic              oob_q;
  logic [31:0]       wr_addr32;
  logic [31:0]       rd_addr32;
  logic              wr_ok;
  logic              rd_ok;

  assign wr_addr32 = 32'(wr_addr_i);
  assign rd_addr32 = 32'(rd_addr_i);
  assign wr_ok     = wr_addr32 < 32'(STORE_BYTES);
  assign rd_ok     = rd_addr32 < 32'(STORE_BYTES);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok) begin
      mem[wr_addr32[SAW-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      oob_q <= !rd_ok;
      if (rd_ok) begin
        rd_data_q <= mem[rd_addr32[SAW-1:0]];
      end
    end
  end

  // out-of-range source bytes read as blank pixels
  assign rd_data_o = oob_q ? '0 : rd_data_q;

endmodule

// File: bench/tb_scaled_glyph_row_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// tb_scaled_glyph_row_rasterizer_unit
// Self-checking bench for the scaled glyph row rasterizer. A directed table
// loads a small glyph and renders known rows. Random phases then reprogram
// the dimensions and color over APB, stream byte loads and row renders, and
// check every mask beat against a local nearest-neighbor row predictor.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_scaled_glyph_row_rasterizer_unit;
  import sgr_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_BEATS = 800;
  localparam int DIR_ROWS     = 24;
  localparam int IN_W         = $bits(sgr_in_t);

  typedef struct packed {
    logic [0:0]         op;
    logic [BADDR_W-1:0] addr;
    logic [BYTE_W-1:0]  value;
    logic [ROW_W-1:0]   row;
    logic               typed;
    logic [MASK_W-1:0]  mask;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  sgr_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  sgr_out_t          out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // glyph image and register shadow
  logic [BYTE_W-1:0]  glyph_mem   [DEF_STORE_BYTES];
  bit                 glyph_known [DEF_STORE_BYTES];
  int unsigned        gw_q, gh_q, tw_q, th_q;
  logic [COLOR_W-1:0] color_q;

  sgr_out_t rows_due [$];
  int       errors;
  int       beats_sent;
  bit       calm;
  int       out_hold;

  // default 8x8 -> 8x8, color 0
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_LOAD,   9'd0,   8'hFF, 6'd0,  1'b0, 64'h0},
    '{OP_LOAD,   9'd1,   8'h80, 6'd63, 1'b0, 64'h0},
    '{OP_LOAD,   9'd2,   8'h01, 6'd0,  1'b0, 64'h0},
    '{OP_LOAD,   9'd3,   8'h00, 6'd21, 1'b0, 64'h0},
    '{OP_LOAD,   9'd4,   8'hA5, 6'd0,  1'b0, 64'h0},
    '{OP_LOAD,   9'd5,   8'h5A, 6'd42, 1'b0, 64'h0},
    '{OP_LOAD,   9'd6,   8'hC3, 6'd0,  1'b0, 64'h0},
    '{OP_LOAD,   9'd7,   8'h3C, 6'd0,  1'b0, 64'h0},
    '{OP_LOAD,   9'd511, 8'hFF, 6'd63, 1'b0, 64'h0},
    '{OP_LOAD,   9'd256, 8'h00, 6'd0,  1'b0, 64'h0},
    '{OP_RENDER, 9'd0,   8'h00, 6'd0,  1'b1, 64'hFF},
    '{OP_RENDER, 9'd0,   8'h00, 6'd1,  1'b1, 64'h01},
    '{OP_RENDER, 9'd0,   8'h00, 6'd2,  1'b1, 64'h80},
    '{OP_RENDER, 9'd0,   8'h00, 6'd3,  1'b1, 64'h00},
    '{OP_RENDER, 9'd0,   8'h00, 6'd4,  1'b1, 64'hA5},
    '{OP_RENDER, 9'd0,   8'h00, 6'd5,  1'b1, 64'h5A},
    '{OP_RENDER, 9'd0,   8'h00, 6'd7,  1'b0, 64'h00},
    '{OP_RENDER, 9'd0,   8'h00, 6'd8,  1'b1, 64'h00},
    '{OP_RENDER, 9'd511, 8'hFF, 6'd63, 1'b1, 64'h00},
    '{OP_LOAD,   9'd0,   8'h00, 6'd0,  1'b0, 64'h0},
    '{OP_RENDER, 9'd0,   8'h00, 6'd0,  1'b1, 64'h00},
    '{OP_RENDER, 9'd0,   8'h00, 6'd6,  1'b0, 64'h00},
    '{OP_LOAD,   9'd6,   8'hFF, 6'd0,  1'b0, 64'h0},
    '{OP_RENDER, 9'd0,   8'h00, 6'd6,  1'b1, 64'hFF}
  };

  scaled_glyph_row_rasterizer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Mask for target row y; hole returns the first needed byte never loaded.
  function automatic logic [MASK_W-1:0] scaled_row_mask(input int unsigned y, output int hole);
    logic [MASK_W-1:0] m;
    int unsigned rb, sy, sx, cols, a;
    m = '0;
    hole = -1;
    if (gw_q == 0 || gh_q == 0 || tw_q == 0 || th_q == 0) return m;
    if (gw_q > DEF_MAX_GLYPH_WIDTH || gh_q > DEF_MAX_GLYPH_HEIGHT) return m;
    if (y >= th_q) return m;
    rb = (gw_q + 7) >> 3;
    sy = (y * gh_q) / th_q;
    cols = (tw_q < MASK_W) ? tw_q : MASK_W;
    for (int unsigned x = 0; x < cols; x++) begin
      sx = (x * gw_q) / tw_q;
      a = sy * rb + (sx >> 3);
      if (a < DEF_STORE_BYTES) begin
        if (!glyph_known[a] && hole < 0) hole = a;
        m[x] = glyph_mem[a][7 - (sx & 7)];
      end
    end
    return m;
  endfunction

  task automatic push_beat(input sgr_in_t beat, input logic typed, input logic [MASK_W-1:0] tmask);
    int gap;
    int hole;
    sgr_out_t due;
    gap = calm ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    beats_sent++;
    if (beat.operation == OP_LOAD) begin
      glyph_mem[beat.byte_address]   = beat.byte_value;
      glyph_known[beat.byte_address] = 1'b1;
    end else begin
      due.row_index   = beat.target_row;
      due.row_mask    = typed ? tmask : scaled_row_mask(32'(beat.target_row), hole);
      due.pixel_color = color_q;
      rows_due.push_back(due);
    end
  endtask

  // a render is preceded by loads of any source byte it would read unwritten
  task automatic issue(input sgr_in_t beat, input logic typed, input logic [MASK_W-1:0] tmask);
    sgr_in_t fill;
    int hole;
    logic [MASK_W-1:0] unused;
    if (beat.operation == OP_RENDER) begin
      unused = scaled_row_mask(32'(beat.target_row), hole);
      while (hole >= 0) begin
        fill = IN_W'($urandom);
        fill.operation    = OP_LOAD;
        fill.byte_address = hole[BADDR_W-1:0];
        push_beat(fill, 1'b0, '0);
        unused = scaled_row_mask(32'(beat.target_row), hole);
      end
    end
    push_beat(beat, typed, tmask);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input logic [2:0] idx, input int unsigned value);
    logic [APB_DW-1:0] fmask, wdata, rdata;
    fmask = (idx == REG_DRAW_COLOR) ? 32'hFF : 32'h7F;
    wdata = ($urandom & ~fmask) | (value & fmask);
    apb_xfer(1'b1, idx, wdata, rdata);
    apb_xfer(1'b0, idx, '0, rdata);
    if ((rdata & fmask) !== (value & fmask)) begin
      $display("%0t: register %0d readback, expected %h got %h", $time, idx, value & fmask,
               rdata & fmask);
      errors++;
    end
    case (idx)
      REG_GLYPH_WIDTH:   gw_q = value & fmask;
      REG_GLYPH_HEIGHT:  gh_q = value & fmask;
      REG_TARGET_WIDTH:  tw_q = value & fmask;
      REG_TARGET_HEIGHT: th_q = value & fmask;
      default:           color_q = COLOR_W'(value & fmask);
    endcase
  endtask

  always @(posedge clk_i) begin
    sgr_out_t due;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected mask beat, got row %0d mask %h color %h", $time,
                 out_data_o.row_index, out_data_o.row_mask, out_data_o.pixel_color);
        errors++;
      end else begin
        due = rows_due.pop_front();
        if (out_data_o.row_index !== due.row_index || out_data_o.row_mask !== due.row_mask ||
            out_data_o.pixel_color !== due.pixel_color) begin
          $display("%0t: mask beat mismatch, expected row %0d mask %h color %h, got row %0d mask %h color %h",
                   $time, due.row_index, due.row_mask, due.pixel_color, out_data_o.row_index,
                   out_data_o.row_mask, out_data_o.pixel_color);
          errors++;
        end
      end
      out_hold = calm ? 0 : $urandom_range(0, 16);
    end
  end

  always @(negedge clk_i) begin
    if (out_valid_o === 1'b1 && out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #40_000_000;
    $display("scaled_glyph_row_rasterizer_unit verification failed");
    $finish;
  end

  initial begin
    sgr_in_t beat;
    int unsigned gw, gh, tw, th, color, cap, area, n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    errors      = 0;
    beats_sent  = 0;
    calm        = 1'b0;
    out_hold    = $urandom_range(0, 16);
    gw_q        = 32'(RST_GLYPH_WIDTH);
    gh_q        = 32'(RST_GLYPH_HEIGHT);
    tw_q        = 32'(RST_TARGET_WIDTH);
    th_q        = 32'(RST_TARGET_HEIGHT);
    color_q     = RST_DRAW_COLOR;
    for (int i = 0; i < DEF_STORE_BYTES; i++) glyph_known[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      beat.operation    = dir_rows[i].op;
      beat.byte_address = dir_rows[i].addr;
      beat.byte_value   = dir_rows[i].value;
      beat.target_row   = dir_rows[i].row;
      issue(beat, dir_rows[i].typed, dir_rows[i].mask);
    end

    while (beats_sent < DIR_ROWS + RANDOM_BEATS) begin
      settle();
      gw = $urandom_range(1, 16);
      gh = $urandom_range(1, 16);
      tw = $urandom_range(1, 24);
      th = $urandom_range(1, 24);
      color = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
        0: begin
          gw = $urandom_range(0, 1) ? 64 : 1;
          gh = $urandom_range(0, 1) ? 64 : 1;
          tw = $urandom_range(0, 1) ? 64 : 1;
          th = $urandom_range(0, 1) ? 64 : 1;
          color = $urandom_range(0, 1) ? 255 : 0;
        end
        1: begin
          case ($urandom_range(0, 3))
            0: gw = 0;
            1: gh = 0;
            2: tw = 0;
            default: th = 0;
          endcase
        end
        2: begin
          if ($urandom_range(0, 1)) gw = $urandom_range(65, 127);
          else gh = $urandom_range(65, 127);
        end
        3: begin
          tw = $urandom_range(65, 127);
          th = $urandom_range(65, 127);
        end
        default: ;
      endcase
      set_reg(REG_GLYPH_WIDTH, gw);
      set_reg(REG_GLYPH_HEIGHT, gh);
      set_reg(REG_TARGET_WIDTH, tw);
      set_reg(REG_TARGET_HEIGHT, th);
      set_reg(REG_DRAW_COLOR, color);
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 60);
      repeat (n) begin
        beat = IN_W'($urandom);
        if ($urandom_range(0, 9) < 6) begin
          beat.operation = OP_RENDER;
          cap = (th_q < 64) ? th_q : 64;
          if (cap > 0 && $urandom_range(0, 4) != 0)
            beat.target_row = ROW_W'($urandom_range(0, cap - 1));
        end else begin
          beat.operation = OP_LOAD;
          area = ((gw_q + 7) >> 3) * gh_q;
          if (area > 0 && area <= DEF_STORE_BYTES && $urandom_range(0, 3) != 0)
            beat.byte_address = BADDR_W'($urandom_range(0, area - 1));
        end
        issue(beat, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("scaled_glyph_row_rasterizer_unit verification clean");
    end else begin
      $display("scaled_glyph_row_rasterizer_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sgr_pkg.sv
rtl/core/sgr_cfg_regs.sv
rtl/core/sgr_step_alu.sv
rtl/core/sgr_glyph_mem.sv
rtl/core/scaled_glyph_row_rasterizer_unit.sv
bench/tb_scaled_glyph_row_rasterizer_unit.sv
